FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pttt_pkg.sv
// types and constants of the periodic task timer table
// no dependencies; used by every module of the block but pttt_ram
`default_nettype none

package pttt_pkg;

    // highest target index that can be loaded
    localparam int unsigned MaxTarget = 25;
    localparam int unsigned TargetCount = 26;

    // configuration port
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 26;
    localparam logic [CfgIdxW-1:0] REG_INTERVAL_MODE = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_LOADED_TARGETS = 1'd1;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_KILL     = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_STARTED    = 3'd0,
        KIND_REJECTED   = 3'd1,
        KIND_FIRED      = 3'd2,
        KIND_ENDED      = 3'd3,
        KIND_KILL_MATCH = 3'd4,
        KIND_KILL_NONE  = 3'd5,
        KIND_TICK_DONE  = 3'd6
    } kind_t;

    // one command beat
    typedef struct packed {
        op_t         op;
        logic [31:0] task_id;
        logic [4:0]  target;
        logic [15:0] initial_delay;
        logic [15:0] interval;
        logic [31:0] run_count;
        logic [1:0]  style;
        logic [31:0] now;
    } cmd_t;

    // one result beat
    typedef struct packed {
        kind_t       kind;
        logic [31:0] out_task_id;
        logic [4:0]  out_target;
        logic [1:0]  out_style;
        logic [31:0] out_time;
        logic        last;
    } res_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [31:0] task_id;
        logic [4:0]  target;
        logic [1:0]  style;
        logic [15:0] interval;
        logic [31:0] runs_left;
        logic [31:0] due_time;
        logic        killed;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCHED,
        ST_KILL_RD,
        ST_KILL_CHK,
        ST_KILL_END,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_END,
        ST_TICK_DONE,
        ST_FINISH
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic  load_item;
        logic  rd_en;
        logic  idx_inc;
        logic  keep_inc;
        logic  emit;
        kind_t emit_kind;
        logic  wr_sched;
        logic  wr_kill;
        logic  wr_keep;
        logic  commit_time;
        logic  commit_count;
        logic  finish;
    } dp_ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic op_known;
        logic sched_ok;
        logic same_time;
        logic idx_end;
        logic match;
        logic killed;
        logic due;
        logic ends;
        logic found;
        logic emit_ok;
        logic finish_ok;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/pttt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module pttt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pttt_ctrl.sv
// sequencer for schedule, kill and tick walks
// depends on pttt_pkg
`default_nettype none

module pttt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire pttt_pkg::dp_status_t   status,
    output pttt_pkg::dp_ctl_t           ctl
);

    pttt_pkg::state_t state_reg;
    pttt_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pttt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != pttt_pkg::ST_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        ctl.emit_kind = pttt_pkg::KIND_STARTED;
        case (state_reg)
            pttt_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next = pttt_pkg::ST_DISPATCH;
                end
            end
            pttt_pkg::ST_DISPATCH:
            begin
                if (!status.op_known)
                begin
                    // unused op code: dropped without results
                    state_next = pttt_pkg::ST_IDLE;
                end
                else
                begin
                    case (status.op)
                        pttt_pkg::OP_SCHEDULE: state_next = pttt_pkg::ST_SCHED;
                        pttt_pkg::OP_KILL:     state_next = pttt_pkg::ST_KILL_RD;
                        pttt_pkg::OP_TICK:
                        begin
                            if (status.same_time)
                            begin
                                state_next = pttt_pkg::ST_TICK_DONE;
                            end
                            else
                            begin
                                ctl.commit_time = 1'b1;
                                state_next = pttt_pkg::ST_TICK_RD;
                            end
                        end
                        default: state_next = pttt_pkg::ST_IDLE;
                    endcase
                end
            end
            pttt_pkg::ST_SCHED:
            begin
                ctl.emit_kind = status.sched_ok ? pttt_pkg::KIND_STARTED
                                                : pttt_pkg::KIND_REJECTED;
                if (status.emit_ok)
                begin
                    ctl.emit = 1'b1;
                    ctl.wr_sched = status.sched_ok;
                    state_next = pttt_pkg::ST_FINISH;
                end
            end
            pttt_pkg::ST_KILL_RD:
            begin
                if (status.idx_end)
                begin
                    state_next = pttt_pkg::ST_KILL_END;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    state_next = pttt_pkg::ST_KILL_CHK;
                end
            end
            pttt_pkg::ST_KILL_CHK:
            begin
                ctl.emit_kind = pttt_pkg::KIND_KILL_MATCH;
                if (!status.match)
                begin
                    ctl.idx_inc = 1'b1;
                    state_next = pttt_pkg::ST_KILL_RD;
                end
                else if (status.emit_ok)
                begin
                    ctl.emit = 1'b1;
                    ctl.wr_kill = 1'b1;
                    ctl.idx_inc = 1'b1;
                    state_next = pttt_pkg::ST_KILL_RD;
                end
            end
            pttt_pkg::ST_KILL_END:
            begin
                ctl.emit_kind = pttt_pkg::KIND_KILL_NONE;
                if (status.found)
                begin
                    state_next = pttt_pkg::ST_FINISH;
                end
                else if (status.emit_ok)
                begin
                    ctl.emit = 1'b1;
                    state_next = pttt_pkg::ST_FINISH;
                end
            end
            pttt_pkg::ST_TICK_RD:
            begin
                if (status.idx_end)
                begin
                    ctl.commit_count = 1'b1;
                    state_next = pttt_pkg::ST_TICK_DONE;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    state_next = pttt_pkg::ST_TICK_CHK;
                end
            end
            pttt_pkg::ST_TICK_CHK:
            begin
                if (status.killed)
                begin
                    // killed entry ends and is dropped
                    ctl.emit_kind = pttt_pkg::KIND_ENDED;
                    if (status.emit_ok)
                    begin
                        ctl.emit = 1'b1;
                        ctl.idx_inc = 1'b1;
                        state_next = pttt_pkg::ST_TICK_RD;
                    end
                end
                else if (status.due)
                begin
                    ctl.emit_kind = pttt_pkg::KIND_FIRED;
                    if (status.emit_ok)
                    begin
                        ctl.emit = 1'b1;
                        if (status.ends)
                        begin
                            state_next = pttt_pkg::ST_TICK_END;
                        end
                        else
                        begin
                            ctl.wr_keep = 1'b1;
                            ctl.keep_inc = 1'b1;
                            ctl.idx_inc = 1'b1;
                            state_next = pttt_pkg::ST_TICK_RD;
                        end
                    end
                end
                else
                begin
                    // not due: compact in place
                    ctl.wr_keep = 1'b1;
                    ctl.keep_inc = 1'b1;
                    ctl.idx_inc = 1'b1;
                    state_next = pttt_pkg::ST_TICK_RD;
                end
            end
            pttt_pkg::ST_TICK_END:
            begin
                ctl.emit_kind = pttt_pkg::KIND_ENDED;
                if (status.emit_ok)
                begin
                    ctl.emit = 1'b1;
                    ctl.idx_inc = 1'b1;
                    state_next = pttt_pkg::ST_TICK_RD;
                end
            end
            pttt_pkg::ST_TICK_DONE:
            begin
                ctl.emit_kind = pttt_pkg::KIND_TICK_DONE;
                if (status.emit_ok)
                begin
                    ctl.emit = 1'b1;
                    state_next = pttt_pkg::ST_FINISH;
                end
            end
            pttt_pkg::ST_FINISH:
            begin
                if (status.finish_ok)
                begin
                    ctl.finish = 1'b1;
                    state_next = pttt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pttt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/pttt_datapath.sv
// table datapath: config registers, counters, slot memory, result hold and output stage
// depends on pttt_pkg and pttt_ram
`default_nettype none

module pttt_datapath #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pttt_pkg::cmd_t                    cmd,
    input  wire logic                              cfg_wen,
    input  wire logic [pttt_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [pttt_pkg::CfgDataW-1:0]     cfg_data,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output pttt_pkg::res_t                         res,
    input  wire pttt_pkg::dp_ctl_t                 ctl,
    output pttt_pkg::dp_status_t                   status
);

    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    pttt_pkg::cmd_t                 item_reg;
    logic                           mode_reg;
    logic [pttt_pkg::CfgDataW-1:0]  loaded_reg;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  keep_reg, keep_next;
    logic [31:0]                    last_time_reg;
    logic                           found_reg, found_next;
    logic                           hold_valid_reg, hold_valid_next;
    pttt_pkg::res_t                 hold_reg;
    logic                           res_valid_reg, res_valid_next;
    pttt_pkg::res_t                 res_reg;

    pttt_pkg::slot_t                slot;
    pttt_pkg::slot_t                slot_upd;
    pttt_pkg::slot_t                slot_new;
    pttt_pkg::slot_t                wr_data;
    logic [IW-1:0]                  wr_addr;
    logic                           wr_en;
    logic [31:0]                    loaded_mask;
    logic [31:0]                    due_base;
    logic                           out_can_load;
    logic                           flush;
    pttt_pkg::res_t                 emit_res;
    pttt_pkg::res_t                 drain_res;

    // slot memory
    pttt_ram #(
        .WIDTH ($bits(pttt_pkg::slot_t)),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (slot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            loaded_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                pttt_pkg::REG_INTERVAL_MODE:  mode_reg <= cfg_data[0];
                pttt_pkg::REG_LOADED_TARGETS: loaded_reg <= cfg_data;
                default:                      mode_reg <= mode_reg;
            endcase
        end
    end

    // latched command
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= cmd;
        end
    end

    // schedule check and new entry
    assign loaded_mask = {{(32 - pttt_pkg::CfgDataW){1'b0}}, loaded_reg};

    always_comb
    begin
        slot_new.task_id   = item_reg.task_id;
        slot_new.target    = item_reg.target;
        slot_new.style     = item_reg.style;
        slot_new.interval  = item_reg.interval;
        slot_new.runs_left = item_reg.run_count;
        slot_new.due_time  = item_reg.now + {16'd0, item_reg.initial_delay};
        slot_new.killed    = 1'b0;
    end

    // entry update on firing
    assign due_base = mode_reg ? item_reg.now : slot.due_time;

    always_comb
    begin
        slot_upd = slot;
        if (status.due)
        begin
            slot_upd.runs_left = slot.runs_left - {31'd0, (slot.runs_left != 32'd0)};
            slot_upd.due_time  = due_base + {16'd0, slot.interval};
        end
    end

    // memory write selection
    always_comb
    begin
        wr_en   = ctl.wr_sched | ctl.wr_kill | ctl.wr_keep;
        wr_addr = keep_reg[IW-1:0];
        wr_data = slot_upd;
        if (ctl.wr_sched)
        begin
            wr_addr = count_reg[IW-1:0];
            wr_data = slot_new;
        end
        else if (ctl.wr_kill)
        begin
            wr_addr = idx_reg[IW-1:0];
            wr_data = slot;
            wr_data.killed = 1'b1;
        end
    end

    // status towards the controller
    always_comb
    begin
        status.op        = item_reg.op;
        status.op_known  = (item_reg.op == pttt_pkg::OP_SCHEDULE) ||
                           (item_reg.op == pttt_pkg::OP_KILL) ||
                           (item_reg.op == pttt_pkg::OP_TICK);
        status.sched_ok  = (count_reg < CW'(ENTRIES)) &&
                           (item_reg.target <= 5'(pttt_pkg::MaxTarget)) &&
                           loaded_mask[item_reg.target];
        status.same_time = (item_reg.now == last_time_reg);
        status.idx_end   = (idx_reg == count_reg);
        status.match     = (slot.task_id == item_reg.task_id) ||
                           (item_reg.task_id == 32'd0);
        status.killed    = slot.killed;
        status.due       = (item_reg.now >= slot.due_time);
        status.ends      = (slot.interval == 16'd0) || (slot.runs_left == 32'd1);
        status.found     = found_reg;
        status.emit_ok   = !hold_valid_reg || out_can_load;
        status.finish_ok = out_can_load;
    end

    // result fields per kind
    always_comb
    begin
        emit_res.kind        = ctl.emit_kind;
        emit_res.out_time    = item_reg.now;
        emit_res.last        = 1'b0;
        emit_res.out_task_id = slot.task_id;
        emit_res.out_target  = slot.target;
        emit_res.out_style   = slot.style;
        case (ctl.emit_kind)
            pttt_pkg::KIND_STARTED, pttt_pkg::KIND_REJECTED:
            begin
                emit_res.out_task_id = item_reg.task_id;
                emit_res.out_target  = item_reg.target;
                emit_res.out_style   = item_reg.style;
            end
            pttt_pkg::KIND_KILL_NONE:
            begin
                emit_res.out_task_id = item_reg.task_id;
                emit_res.out_target  = '0;
                emit_res.out_style   = '0;
            end
            pttt_pkg::KIND_TICK_DONE:
            begin
                emit_res.out_task_id = '0;
                emit_res.out_target  = '0;
                emit_res.out_style   = '0;
            end
            default:
            begin
                emit_res.out_task_id = slot.task_id;
            end
        endcase
    end

    // counters, hold stage and output stage
    assign out_can_load = !res_valid_reg || !res_stall;
    assign flush = hold_valid_reg && (ctl.emit || ctl.finish);

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        res_valid_next  = res_valid_reg;
        if (ctl.load_item)
        begin
            idx_next   = '0;
            keep_next  = '0;
            found_next = 1'b0;
        end
        if (ctl.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (ctl.keep_inc)
        begin
            keep_next = keep_reg + CW'(1);
        end
        if (ctl.wr_sched)
        begin
            count_next = count_reg + CW'(1);
        end
        if (ctl.commit_count)
        begin
            count_next = keep_reg;
        end
        if (ctl.wr_kill)
        begin
            found_next = 1'b1;
        end
        if (ctl.emit)
        begin
            hold_valid_next = 1'b1;
        end
        else if (ctl.finish)
        begin
            hold_valid_next = 1'b0;
        end
        if (flush)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            last_time_reg  <= '0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
            if (ctl.commit_time)
            begin
                last_time_reg <= item_reg.now;
            end
        end
    end

    // drained beat carries last only when the command finishes
    always_comb
    begin
        drain_res      = hold_reg;
        drain_res.last = ctl.finish;
    end

    // payload of hold and output stages; last is settled when the hold stage drains
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            hold_reg <= emit_res;
        end
        if (flush)
        begin
            res_reg <= drain_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/periodic_task_timer_table_core.sv
// top level of the periodic task timer table: controller plus datapath
// depends on pttt_pkg, pttt_ctrl, pttt_datapath (and through it pttt_ram)
// one command at a time; each schedule, tick or kill walk ends before the next is taken
// a firing entry that ends passes through ST_TICK_END; an unused op is dropped
// beats pass through a hold stage; walks wait while it is full and the output is stalled
// async active-low reset clears control state; slot contents stay undefined until written
`default_nettype none

module periodic_task_timer_table_core #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire pttt_pkg::cmd_t                cmd,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output pttt_pkg::res_t                     res,
    input  wire logic                          cfg_wen,
    input  wire logic [pttt_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [pttt_pkg::CfgDataW-1:0] cfg_data
);

    pttt_pkg::dp_ctl_t    ctl;
    pttt_pkg::dp_status_t status;

    // sequencer
    pttt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctl       (ctl)
    );

    // table datapath
    pttt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .ctl       (ctl),
        .status    (status)
    );

endmodule

`default_nettype wire

FILE: rtl/pttt_checker.sv
// port-level checks on the result channel of the timer table, bound to the top level
// depends on pttt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pttt_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire pttt_pkg::res_t res
);

    // a stalled beat stays put
    `ASSERT_CLK_RST(a_res_hold, clk, rst_n, res_valid && res_stall |=> res_valid && $stable(res), "stalled result beat changed")

    // single-result kinds and the tick summary always close their command
    `ASSERT_CLK_RST(a_closing_last, clk, rst_n, res_valid && (res.kind == pttt_pkg::KIND_STARTED || res.kind == pttt_pkg::KIND_REJECTED || res.kind == pttt_pkg::KIND_KILL_NONE || res.kind == pttt_pkg::KIND_TICK_DONE) |-> res.last, "closing result without last")

    // fired and ended beats are always followed by the tick summary
    `ASSERT_CLK_RST(a_walk_not_last, clk, rst_n, res_valid && (res.kind == pttt_pkg::KIND_FIRED || res.kind == pttt_pkg::KIND_ENDED) |-> !res.last, "walk result marked last")

    // stored tasks only ever name a valid target
    `ASSERT_CLK_RST(a_target_range, clk, rst_n, res_valid && (res.kind == pttt_pkg::KIND_STARTED || res.kind == pttt_pkg::KIND_FIRED || res.kind == pttt_pkg::KIND_ENDED || res.kind == pttt_pkg::KIND_KILL_MATCH) |-> res.out_target <= 5'(pttt_pkg::MaxTarget), "target out of range")

    // no beat during reset
    `ASSERT_CLK(a_reset_quiet, clk, !rst_n |-> !res_valid, "result valid in reset")

endmodule

bind periodic_task_timer_table_core pttt_checker u_pttt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
